>>> hdl/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int unsigned SLOT_COUNT_DEF     = 8;
	localparam int unsigned SYSTEM_ADDRESS_DEF = 100;
	localparam logic [7:0]  ERROR_ADDRESS      = 8'd15;
	localparam logic [3:0]  COUNT_MAX          = 4'd15;

	typedef enum logic [3:0] {
		ACT_ALLOC_USER = 4'd0,
		ACT_ALLOC_SYS  = 4'd1,
		ACT_ALLOC_RUN  = 4'd2,
		ACT_FREE       = 4'd3,
		ACT_FREE_MATCH = 4'd4,
		ACT_FIND       = 4'd5,
		ACT_DIRTY      = 4'd6,
		ACT_CLEAN      = 4'd7,
		ACT_ASSIGN     = 4'd8
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NO_FREE = 2'd1,
		ST_MISS    = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_EVAL,
		S_FILL,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic       alloc;
		logic [7:0] addr;
		logic       dirty;
		logic       sticky;
	} slot_rec_t;

	typedef struct packed {
		logic       include_sticky;
		logic       include_system;
		logic       sticky_value;
		logic [7:0] address;
		logic [3:0] run_length;
		logic [3:0] slot;
	} req_t;

	typedef struct packed {
		logic [3:0] dirty_count;
		logic [3:0] active_count;
		logic [3:0] result_slot;
		status_t    status;
	} result_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} store_ctl_t;

	function automatic logic [3:0] cnt_up(input logic [3:0] c);
		return (c == COUNT_MAX) ? c : c + 4'd1;
	endfunction

	function automatic logic [3:0] cnt_down(input logic [3:0] c);
		return (c == 4'd0) ? c : c - 4'd1;
	endfunction

endpackage

>>> hdl/bpa_ram.sv
`timescale 1ns / 1ps

module bpa_ram #(
	parameter int unsigned WIDTH = 11,
	parameter int unsigned DEPTH = 9,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/bpa_slot_store.sv
`timescale 1ns / 1ps

module bpa_slot_store #(
	parameter int unsigned SLOT_COUNT = bpa_pkg::SLOT_COUNT_DEF,
	localparam int unsigned IW = $clog2(SLOT_COUNT + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bpa_pkg::store_ctl_t   ctl,
	input  logic [IW-1:0]         rd_idx,
	input  logic [IW-1:0]         wr_idx,
	input  bpa_pkg::slot_rec_t    wr_data,
	output bpa_pkg::slot_rec_t    rd_data
);
	import bpa_pkg::*;

	localparam int unsigned DEPTH = SLOT_COUNT + 1;
	localparam slot_rec_t ERR_REC = '{alloc: 1'b1, addr: ERROR_ADDRESS, dirty: 1'b0,
		sticky: 1'b0};

	logic [DEPTH-1:0] valid_q;
	logic             rd_valid_q;
	logic             rd_err_q;
	slot_rec_t        ram_rdata;

	bpa_ram #(
		.WIDTH($bits(slot_rec_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr(wr_idx),
		.wdata(wr_data),
		.re   (ctl.rd_en),
		.raddr(rd_idx),
		.rdata(ram_rdata)
	);

	// An entry never written reads as its reset value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
			rd_err_q   <= 1'b0;
		end else begin
			if (ctl.wr_en) begin
				valid_q[wr_idx] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_q <= valid_q[rd_idx];
				rd_err_q   <= (rd_idx == IW'(SLOT_COUNT));
			end
		end
	end

	always_comb begin
		if (rd_valid_q) begin
			rd_data = ram_rdata;
		end else if (rd_err_q) begin
			rd_data = ERR_REC;
		end else begin
			rd_data = '0;
		end
	end

endmodule

>>> hdl/bpa_seq.sv
`timescale 1ns / 1ps

module bpa_seq #(
	parameter int unsigned SLOT_COUNT     = bpa_pkg::SLOT_COUNT_DEF,
	parameter int unsigned SYSTEM_ADDRESS = bpa_pkg::SYSTEM_ADDRESS_DEF,
	localparam int unsigned IW = $clog2(SLOT_COUNT + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bpa_pkg::action_t    in_action,
	input  bpa_pkg::req_t       in_req,
	output logic                done_valid,
	input  logic                done_ready,
	output bpa_pkg::result_t    done_res,
	output bpa_pkg::store_ctl_t ctl,
	output logic [IW-1:0]       rd_idx,
	output logic [IW-1:0]       wr_idx,
	output bpa_pkg::slot_rec_t  wr_data,
	input  bpa_pkg::slot_rec_t  rd_data
);
	import bpa_pkg::*;

	localparam logic [3:0] LAST_SLOT = 4'(SLOT_COUNT);
	localparam logic [7:0] SYS_ADDR  = 8'(SYSTEM_ADDRESS);

	seq_state_t    state_q, state_d;
	action_t       op_q, op_d;
	req_t          req_q, req_d;
	logic [IW-1:0] idx_q, idx_d;
	logic [IW-1:0] last_q, last_d;
	logic [IW-1:0] start_q, start_d;
	logic [IW-1:0] result_q, result_d;
	logic [3:0]    run_q, run_d;
	status_t       status_q, status_d;
	logic [3:0]    user_count_q, user_count_d;
	logic [3:0]    marked_count_q, marked_count_d;

	slot_rec_t     rec;
	logic          stop;
	logic          fill_go;
	logic          release_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_count_q   <= '0;
			marked_count_q <= '0;
		end else begin
			user_count_q   <= user_count_d;
			marked_count_q <= marked_count_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q     <= op_d;
		req_q    <= req_d;
		idx_q    <= idx_d;
		last_q   <= last_d;
		start_q  <= start_d;
		result_q <= result_d;
		run_q    <= run_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d        = state_q;
		op_d           = op_q;
		req_d          = req_q;
		idx_d          = idx_q;
		last_d         = last_q;
		start_d        = start_q;
		result_d       = result_q;
		run_d          = run_q;
		status_d       = status_q;
		user_count_d   = user_count_q;
		marked_count_d = marked_count_q;
		ctl            = '0;
		rd_idx         = idx_q;
		wr_idx         = idx_q;
		rec            = rd_data;
		wr_data        = rd_data;
		in_ready       = 1'b0;
		done_valid     = 1'b0;
		stop           = 1'b0;
		fill_go        = 1'b0;
		release_ok     = 1'b0;
		done_res       = '{dirty_count: marked_count_q, active_count: user_count_q,
			result_slot: 4'(result_q), status: status_q};

		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d     = in_action;
					req_d    = in_req;
					idx_d    = '0;
					last_d   = IW'(SLOT_COUNT - 1);
					run_d    = '0;
					result_d = '0;
					status_d = ST_OK;
					state_d  = S_READ;
					case (in_action)
						ACT_ALLOC_USER, ACT_ALLOC_SYS: begin
							status_d = ST_NO_FREE;
						end
						ACT_ALLOC_RUN: begin
							status_d = ST_NO_FREE;
							if (in_req.run_length == 4'd0 || in_req.run_length > LAST_SLOT) begin
								state_d = S_DONE;
							end
						end
						ACT_FREE: begin
							status_d = ST_MISS;
							if (in_req.slot > LAST_SLOT) begin
								state_d = S_DONE;
							end else begin
								idx_d  = in_req.slot[IW-1:0];
								last_d = in_req.slot[IW-1:0];
							end
						end
						ACT_FREE_MATCH: begin
							status_d = ST_OK;
						end
						ACT_FIND: begin
							status_d = ST_MISS;
							last_d   = IW'(SLOT_COUNT);
						end
						ACT_DIRTY, ACT_CLEAN: begin
							if (in_req.slot > LAST_SLOT) begin
								status_d = ST_MISS;
								state_d  = S_DONE;
							end else begin
								idx_d  = in_req.slot[IW-1:0];
								last_d = in_req.slot[IW-1:0];
							end
						end
						ACT_ASSIGN: begin
							if (in_req.slot >= LAST_SLOT) begin
								status_d = ST_MISS;
								state_d  = S_DONE;
							end else begin
								idx_d  = in_req.slot[IW-1:0];
								last_d = in_req.slot[IW-1:0];
							end
						end
						default: begin
							status_d = ST_MISS;
							state_d  = S_DONE;
						end
					endcase
				end
			end
			S_READ: begin
				ctl.rd_en = 1'b1;
				state_d   = S_EVAL;
			end
			S_EVAL: begin
				case (op_q)
					ACT_ALLOC_USER, ACT_ALLOC_SYS: begin
						if (!rec.alloc) begin
							ctl.wr_en = 1'b1;
							wr_data   = '{alloc: 1'b1, addr: 8'd0, dirty: 1'b0, sticky: 1'b0};
							if (op_q == ACT_ALLOC_SYS) begin
								wr_data.addr = SYS_ADDR;
							end else begin
								user_count_d = cnt_up(user_count_q);
							end
							status_d = ST_OK;
							result_d = idx_q;
							stop     = 1'b1;
						end
					end
					ACT_ALLOC_RUN: begin
						if (rec.alloc) begin
							run_d = '0;
						end else begin
							run_d = run_q + 4'd1;
							if (run_q == 4'd0) begin
								start_d = idx_q;
							end
							if (run_q + 4'd1 == req_q.run_length) begin
								fill_go = 1'b1;
								run_d   = '0;
								idx_d   = (run_q == 4'd0) ? idx_q : start_q;
							end
						end
					end
					ACT_FREE: begin
						release_ok = rec.alloc && rec.addr != ERROR_ADDRESS;
						stop       = 1'b1;
						if (release_ok) begin
							status_d = ST_OK;
						end
					end
					ACT_FREE_MATCH: begin
						release_ok = rec.alloc && rec.addr != ERROR_ADDRESS
							&& (req_q.include_system || rec.addr < SYS_ADDR)
							&& (req_q.include_sticky || !rec.sticky);
					end
					ACT_FIND: begin
						if (rec.alloc && rec.addr == req_q.address) begin
							status_d = ST_OK;
							result_d = idx_q;
							stop     = 1'b1;
						end
					end
					ACT_DIRTY: begin
						stop = 1'b1;
						if (!rec.dirty) begin
							ctl.wr_en      = 1'b1;
							wr_data.dirty  = 1'b1;
							marked_count_d = cnt_up(marked_count_q);
						end
					end
					ACT_CLEAN: begin
						stop = 1'b1;
						if (rec.dirty) begin
							ctl.wr_en      = 1'b1;
							wr_data.dirty  = 1'b0;
							marked_count_d = cnt_down(marked_count_q);
						end
					end
					ACT_ASSIGN: begin
						stop           = 1'b1;
						ctl.wr_en      = 1'b1;
						wr_data.addr   = req_q.address;
						wr_data.sticky = req_q.sticky_value;
					end
					default: begin
						stop = 1'b1;
					end
				endcase

				if (release_ok) begin
					ctl.wr_en     = 1'b1;
					wr_data.alloc = 1'b0;
					wr_data.dirty = 1'b0;
					if (rec.dirty) begin
						marked_count_d = cnt_down(marked_count_q);
					end
					if (rec.addr < SYS_ADDR) begin
						user_count_d = cnt_down(user_count_q);
					end
				end

				if (fill_go) begin
					state_d = S_FILL;
				end else if (stop || idx_q == last_q) begin
					state_d = S_DONE;
				end else begin
					idx_d   = idx_q + IW'(1);
					state_d = S_READ;
				end
			end
			S_FILL: begin
				ctl.wr_en    = 1'b1;
				wr_data      = '{alloc: 1'b1, addr: 8'd0, dirty: 1'b0, sticky: 1'b0};
				user_count_d = cnt_up(user_count_q);
				run_d        = run_q + 4'd1;
				idx_d        = idx_q + IW'(1);
				if (run_q + 4'd1 == req_q.run_length) begin
					status_d = ST_OK;
					result_d = start_q;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				done_valid = 1'b1;
				if (done_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_en |-> !ctl.wr_en)
		else $error("slot store read and write in the same cycle");

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> $past(state_q) == S_READ)
		else $error("evaluation without a preceding read");

	a_user_count_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		user_count_q != $past(user_count_q) |-> $past(ctl.wr_en))
		else $error("active count changed without a slot write");

	a_marked_count_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		marked_count_q != $past(marked_count_q) |-> $past(ctl.wr_en))
		else $error("dirty count changed without a slot write");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done_valid && !done_ready |=> done_valid && $stable(done_res))
		else $error("finished result dropped or changed while stalled");
`endif

endmodule

>>> hdl/buffer_pool_allocator_top.sv
`timescale 1ns / 1ps

// Channel  Direction  Ports                                  Beat
// s_*      in         s_tvalid s_tready s_tdata s_tuser     one request
// m_*      out        m_tvalid m_tready m_tdata             one result per request
//
// Each request walks the slot store entry by entry in a read/modify/write loop (S_READ,
// then S_EVAL), and a run allocation then writes its slots in S_FILL; out-of-range
// requests skip the loop and go straight from S_IDLE to S_DONE.
// The result register frees the sequencer, so a request is taken while a result waits.
// Reset is asynchronous and takes effect at once; there is no clearing pass.
module buffer_pool_allocator_top #(
	parameter int unsigned SLOT_COUNT     = bpa_pkg::SLOT_COUNT_DEF,
	parameter int unsigned SYSTEM_ADDRESS = bpa_pkg::SYSTEM_ADDRESS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot, run_length, address, sticky_value, include_system, include_sticky
	input  logic [23:0] s_tdata,
	// action
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status, result_slot, active_count, dirty_count
	output logic [15:0] m_tdata
);
	import bpa_pkg::*;

	localparam int unsigned IW = $clog2(SLOT_COUNT + 1);

	req_t          req;
	result_t       done_res;
	logic          done_valid;
	logic          done_ready;
	store_ctl_t    ctl;
	logic [IW-1:0] rd_idx;
	logic [IW-1:0] wr_idx;
	slot_rec_t     wr_data;
	slot_rec_t     rd_data;
	logic          m_valid_q;
	result_t       m_res_q;

	assign req = req_t'(s_tdata[$bits(req_t)-1:0]);

	bpa_seq #(
		.SLOT_COUNT    (SLOT_COUNT),
		.SYSTEM_ADDRESS(SYSTEM_ADDRESS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (action_t'(s_tuser)),
		.in_req    (req),
		.done_valid(done_valid),
		.done_ready(done_ready),
		.done_res  (done_res),
		.ctl       (ctl),
		.rd_idx    (rd_idx),
		.wr_idx    (wr_idx),
		.wr_data   (wr_data),
		.rd_data   (rd_data)
	);

	bpa_slot_store #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_idx (rd_idx),
		.wr_idx (wr_idx),
		.wr_data(wr_data),
		.rd_data(rd_data)
	);

	assign done_ready = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (done_ready) begin
			m_valid_q <= done_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (done_valid && done_ready) begin
			m_res_q <= done_res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, m_res_q};

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import bpa_pkg::*;

	localparam int unsigned NSLOTS   = SLOT_COUNT_DEF;
	localparam logic [7:0]  SYS_ADDR = 8'(SYSTEM_ADDRESS_DEF);
	localparam logic [3:0]  ACT_CODE_MAX = 4'hF;
	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef enum int unsigned {RX_FREE, RX_COIN, RX_PULSE, RX_SPARSE} rx_mode_t;

	class pool_scoreboard;
		bit          taken[0:NSLOTS];
		logic [7:0]  tag[0:NSLOTS];
		bit          dirty[0:NSLOTS];
		bit          sticky[0:NSLOTS];
		logic [3:0]  user_cnt;
		logic [3:0]  dirty_cnt;
		result_t     pending_results[$];
		int unsigned failures;

		function new();
			for (int unsigned i = 0; i <= NSLOTS; i++) begin
				taken[i] = 1'b0;
				tag[i] = 8'd0;
				dirty[i] = 1'b0;
				sticky[i] = 1'b0;
			end
			taken[NSLOTS] = 1'b1;
			tag[NSLOTS] = ERROR_ADDRESS;
			user_cnt = 4'd0;
			dirty_cnt = 4'd0;
			failures = 0;
		endfunction

		function logic [3:0] sat_up(logic [3:0] c);
			return (c == COUNT_MAX) ? c : c + 4'd1;
		endfunction

		function logic [3:0] sat_down(logic [3:0] c);
			return (c == 4'd0) ? c : c - 4'd1;
		endfunction

		// Allocation clears the dirty mark without touching the dirty count.
		function void claim(int unsigned i, logic [7:0] a);
			taken[i] = 1'b1;
			tag[i] = a;
			dirty[i] = 1'b0;
			sticky[i] = 1'b0;
		endfunction

		function bit release_entry(int unsigned i);
			if (i > NSLOTS) return 1'b0;
			if (tag[i] == ERROR_ADDRESS) return 1'b0;
			if (!taken[i]) return 1'b0;
			taken[i] = 1'b0;
			if (dirty[i]) begin
				dirty[i] = 1'b0;
				dirty_cnt = sat_down(dirty_cnt);
			end
			if (tag[i] < SYS_ADDR)
				user_cnt = sat_down(user_cnt);
			return 1'b1;
		endfunction

		function void note_request(logic [3:0] act, req_t r);
			result_t     e;
			int unsigned run_len;
			int unsigned start;
			e.status = ST_MISS;
			e.result_slot = 4'd0;
			case (act)
				ACT_ALLOC_USER, ACT_ALLOC_SYS: begin
					e.status = ST_NO_FREE;
					for (int unsigned i = 0; i < NSLOTS; i++) begin
						if (!taken[i]) begin
							if (act == ACT_ALLOC_USER) begin
								claim(i, 8'd0);
								user_cnt = sat_up(user_cnt);
							end else begin
								claim(i, SYS_ADDR);
							end
							e.status = ST_OK;
							e.result_slot = i[3:0];
							break;
						end
					end
				end
				ACT_ALLOC_RUN: begin
					e.status = ST_NO_FREE;
					run_len = 0;
					start = 0;
					if (r.run_length != 4'd0) begin
						for (int unsigned i = 0; i < NSLOTS; i++) begin
							if (taken[i]) begin
								run_len = 0;
							end else begin
								if (run_len == 0)
									start = i;
								run_len++;
								if (run_len == r.run_length)
									break;
							end
						end
						if (run_len == r.run_length) begin
							for (int unsigned i = start; i < start + r.run_length; i++) begin
								claim(i, 8'd0);
								user_cnt = sat_up(user_cnt);
							end
							e.status = ST_OK;
							e.result_slot = start[3:0];
						end
					end
				end
				ACT_FREE: begin
					if (release_entry(32'(r.slot)))
						e.status = ST_OK;
				end
				ACT_FREE_MATCH: begin
					for (int unsigned i = 0; i < NSLOTS; i++) begin
						if (taken[i] && (r.include_system || tag[i] < SYS_ADDR) &&
								(r.include_sticky || !sticky[i]))
							void'(release_entry(i));
					end
					e.status = ST_OK;
				end
				ACT_FIND: begin
					for (int unsigned i = 0; i <= NSLOTS; i++) begin
						if (taken[i] && tag[i] == r.address) begin
							e.status = ST_OK;
							e.result_slot = i[3:0];
							break;
						end
					end
				end
				ACT_DIRTY: begin
					if (r.slot <= NSLOTS) begin
						if (!dirty[r.slot]) begin
							dirty[r.slot] = 1'b1;
							dirty_cnt = sat_up(dirty_cnt);
						end
						e.status = ST_OK;
					end
				end
				ACT_CLEAN: begin
					if (r.slot <= NSLOTS) begin
						if (dirty[r.slot]) begin
							dirty[r.slot] = 1'b0;
							dirty_cnt = sat_down(dirty_cnt);
						end
						e.status = ST_OK;
					end
				end
				ACT_ASSIGN: begin
					if (r.slot < NSLOTS) begin
						tag[r.slot] = r.address;
						sticky[r.slot] = r.sticky_value;
						e.status = ST_OK;
					end
				end
				default: begin
				end
			endcase
			e.active_count = user_cnt;
			e.dirty_count = dirty_cnt;
			pending_results.push_back(e);
		endfunction

		function void check_result(logic [15:0] beat);
			result_t got;
			result_t want;
			got = result_t'(beat[13:0]);
			if (pending_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result beat %h with nothing pending", beat);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status || got.result_slot !== want.result_slot ||
					got.active_count !== want.active_count ||
					got.dirty_count !== want.dirty_count) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("exp/got status %0d/%0d slot %0d/%0d act %0d/%0d dirty %0d/%0d",
						want.status, got.status, want.result_slot, got.result_slot,
						want.active_count, got.active_count, want.dirty_count, got.dirty_count);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = 24'd0;
	logic [3:0]  s_tuser = 4'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	pool_scoreboard pool = new();

	int unsigned burst_left = 1;
	rx_mode_t    rx_mode = RX_FREE;
	int unsigned rx_mode_left = 0;
	int unsigned rx_tick = 0;

	buffer_pool_allocator_top #(
		.SLOT_COUNT(NSLOTS),
		.SYSTEM_ADDRESS(SYSTEM_ADDRESS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(RX_FREE, RX_SPARSE));
			rx_mode_left <= $urandom_range(50, 300);
		end else begin
			rx_mode_left <= rx_mode_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			RX_FREE:  m_tready <= 1'b1;
			RX_COIN:  m_tready <= ($urandom_range(0, 1) == 1);
			RX_PULSE: m_tready <= ((rx_tick % 7) < 3);
			default:  m_tready <= ((rx_tick % 23) < 2);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			pool.check_result(m_tdata);
	end

	task automatic send_request(input logic [3:0] act, input req_t r);
		int unsigned gap;
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {5'd0, r};
		do
			@(posedge clk);
		while (!s_tready);
		pool.note_request(act, r);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic issue(input logic [3:0] act, input logic [3:0] slot, input logic [3:0] len,
			input logic [7:0] addr, input logic stk, input logic inc_sys, input logic inc_stk);
		req_t r;
		r.slot = slot;
		r.run_length = len;
		r.address = addr;
		r.sticky_value = stk;
		r.include_system = inc_sys;
		r.include_sticky = inc_stk;
		send_request(act, r);
	endtask

	function automatic logic [7:0] pick_address();
		case ($urandom_range(0, 5))
			0: return 8'd0;
			1: return ERROR_ADDRESS;
			2: return SYS_ADDR;
			3: return SYS_ADDR - 8'd1;
			4: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [3:0]  act;
		req_t        r;
		int unsigned pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(ACT_FIND,       4'd0,  4'd0,  ERROR_ADDRESS, 1'b0, 1'b0, 1'b0);
		issue(ACT_FREE,       4'(NSLOTS), 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_FREE,       4'd3,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_FREE,       4'hF,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_ALLOC_RUN,  4'd0,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_ALLOC_RUN,  4'd0,  4'(NSLOTS + 1), 8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_ALLOC_RUN,  4'd0,  4'hF,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_ALLOC_USER, 4'hF,  4'hF,  8'hFF, 1'b1, 1'b1, 1'b1);
		issue(ACT_ALLOC_SYS,  4'd0,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_ALLOC_RUN,  4'd0,  4'd3,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_DIRTY,      4'(NSLOTS), 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_DIRTY,      4'd5,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_DIRTY,      4'(NSLOTS + 1), 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_CLEAN,      4'hF,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_DIRTY,      4'd0,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_ASSIGN,     4'd0,  4'd0,  8'hFF, 1'b1, 1'b0, 1'b0);
		issue(ACT_ASSIGN,     4'(NSLOTS), 4'd0, 8'd0, 1'b1, 1'b0, 1'b0);
		issue(ACT_ASSIGN,     4'hF,  4'd0,  8'd1, 1'b0, 1'b0, 1'b0);
		issue(ACT_FIND,       4'd0,  4'd0,  8'hFF, 1'b0, 1'b0, 1'b0);
		issue(ACT_FREE_MATCH, 4'd0,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_FREE_MATCH, 4'd0,  4'd0,  8'd0, 1'b0, 1'b1, 1'b1);
		issue(4'(ACT_ASSIGN + 1), 4'd0, 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_CODE_MAX,   4'hF,  4'hF,  8'hFF, 1'b1, 1'b1, 1'b1);
		issue(ACT_CLEAN,      4'd5,  4'd0,  8'd0, 1'b0, 1'b0, 1'b0);
		issue(ACT_CLEAN,      4'(NSLOTS), 4'd0, 8'd0, 1'b0, 1'b0, 1'b0);

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 16)      act = ACT_ALLOC_USER;
			else if (pick < 24) act = ACT_ALLOC_SYS;
			else if (pick < 34) act = ACT_ALLOC_RUN;
			else if (pick < 50) act = ACT_FREE;
			else if (pick < 55) act = ACT_FREE_MATCH;
			else if (pick < 67) act = ACT_FIND;
			else if (pick < 77) act = ACT_DIRTY;
			else if (pick < 85) act = ACT_CLEAN;
			else if (pick < 97) act = ACT_ASSIGN;
			else                act = 4'($urandom_range(ACT_ASSIGN + 1, ACT_CODE_MAX));
			r.slot = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(0, NSLOTS));
			r.run_length = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) :
				4'($urandom_range(1, 4));
			r.address = pick_address();
			r.sticky_value = 1'($urandom_range(0, 1));
			r.include_system = 1'($urandom_range(0, 1));
			r.include_sticky = 1'($urandom_range(0, 1));
			send_request(act, r);
		end
		s_tvalid <= 1'b0;

		while (pool.pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (pool.failures == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_slot_store.sv
hdl/bpa_seq.sv
hdl/buffer_pool_allocator_top.sv
sim/tb_top.sv
